// ===== design/palette_nearest_color_match_defines.svh =====
// assertion helpers for the palette match rtl
`ifndef PALETTE_NEAREST_COLOR_MATCH_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_MATCH_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PALNC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("palette match check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define PALNC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("palette match check failed");

`endif

// ===== design/palnc_pkg.sv =====
package palnc_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COMP_W      = 16;
  localparam int COLOR_W     = 3 * COMP_W;
  localparam int CODE_W      = 32;
  localparam int DIST_W      = COMP_W + 2;
  localparam int STATUS_W    = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_EXACT     = 3'd0;
  localparam status_t ST_NEAREST   = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_INSERTED  = 3'd3;
  localparam status_t ST_DUPLICATE = 3'd4;
  localparam status_t ST_FULL      = 3'd5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // request travelling down the row of cells, with the running search result
  typedef struct packed {
    logic               vld;
    logic               op;
    logic               dup;
    logic               hit;
    logic [COLOR_W-1:0] color;
    logic [CODE_W-1:0]  code;
    logic [DIST_W-1:0]  best_dist;
    logic [COLOR_W-1:0] best_color;
    logic [CODE_W-1:0]  best_code;
  } token_t;

  function automatic logic [COMP_W-1:0] absdiff(input logic [COMP_W-1:0] a,
                                                input logic [COMP_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== design/palnc_cell.sv =====
module palnc_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    occupied,
  input  logic                    wr,
  input  logic [palnc_pkg::COLOR_W-1:0] wr_color,
  input  logic [palnc_pkg::CODE_W-1:0]  wr_code,
  input  palnc_pkg::token_t       tok_in,
  output palnc_pkg::token_t       tok_out
);
  import palnc_pkg::*;

  logic [COLOR_W-1:0] ent_color;
  logic [CODE_W-1:0]  ent_code;
  logic [DIST_W-1:0]  sad;
  logic               better;
  token_t             tok_next;

  // l1 distance from the stored color to the request color
  always_comb begin
    sad = DIST_W'(absdiff(ent_color[3*COMP_W-1:2*COMP_W], tok_in.color[3*COMP_W-1:2*COMP_W]))
        + DIST_W'(absdiff(ent_color[2*COMP_W-1:COMP_W], tok_in.color[2*COMP_W-1:COMP_W]))
        + DIST_W'(absdiff(ent_color[COMP_W-1:0], tok_in.color[COMP_W-1:0]));
    better = !tok_in.hit || (sad < tok_in.best_dist)
          || ((sad == tok_in.best_dist) && (ent_color < tok_in.best_color));
  end

  always_comb begin
    tok_next = tok_in;
    if (tok_in.vld && occupied) begin
      if (tok_in.op == OP_QUERY) begin
        if (better) begin
          tok_next.hit        = 1'b1;
          tok_next.best_dist  = sad;
          tok_next.best_color = ent_color;
          tok_next.best_code  = ent_code;
        end
      end else if (ent_color == tok_in.color) begin
        tok_next.dup = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      ent_color <= wr_color;
      ent_code  <= wr_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== design/palette_nearest_color_match.sv =====
// a request walks through the row of palette cells, one register per cell, and its result is
//   then registered in the output register that drives m_tvalid; the walk moves one cell per
//   cycle while the row is not stalled, and the next request is not taken until it leaves the last cell
// a waiting result does not block the next request; a result that finds the output
//   still full holds the whole row until the output drains
// reset (rst, synchronous) empties the table and the output; entry contents are not cleared
`include "palette_nearest_color_match_defines.svh"

module palette_nearest_color_match (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // red [15:0], green [31:16], blue [47:32], pixel_in [79:48]
  input  logic [0:0]  s_tuser,   // op [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_out [31:0]
  output logic [2:0]  m_tuser    // status [2:0]
);
  import palnc_pkg::*;

  // tok[k] feeds cell k; tok[TABLE_DEPTH] leaves the last cell
  token_t                tok [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:1]  tok_vld;
  logic [TABLE_DEPTH-1:0] occupied;
  logic [TABLE_DEPTH-1:0] wr;

  logic [CNT_W-1:0] count;
  logic             busy;
  logic             out_valid;
  logic [CODE_W-1:0] out_pixel;
  status_t          out_status;

  logic    accept;
  logic    stall;
  logic    advance;
  logic    finish;
  logic    fin_write;
  logic [CODE_W-1:0] fin_pixel;
  status_t fin_status;
  token_t  tail;

  // one request in flight at a time
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  // request enters the row straight from the slave side
  always_comb begin
    tok[0]            = '0;
    tok[0].vld        = accept;
    tok[0].op         = s_tuser[0];
    tok[0].color      = {s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]};
    tok[0].code       = s_tdata[79:48];
  end

  assign tail    = tok[TABLE_DEPTH];
  // hold the row while a finished request cannot reach the output register
  assign stall   = tail.vld && out_valid && !m_tready;
  assign advance = !stall;
  assign finish  = tail.vld && advance;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      assign occupied[gi] = CNT_W'(gi) < count;
      assign wr[gi]       = fin_write && (count == CNT_W'(gi));
      assign tok_vld[gi+1] = tok[gi+1].vld;

      palnc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (advance),
        .occupied (occupied[gi]),
        .wr       (wr[gi]),
        .wr_color (tail.color),
        .wr_code  (tail.code),
        .tok_in   (tok[gi]),
        .tok_out  (tok[gi+1])
      );
    end
  endgenerate

  // result of the request leaving the last cell
  always_comb begin
    fin_write  = 1'b0;
    fin_pixel  = '0;
    fin_status = ST_EMPTY;
    if (tail.op == OP_INSERT) begin
      if (tail.dup) begin
        fin_status = ST_DUPLICATE;
      end else if (count >= CNT_W'(TABLE_DEPTH)) begin
        fin_status = ST_FULL;
      end else begin
        fin_status = ST_INSERTED;
        fin_write  = finish;
      end
    end else if (tail.hit) begin
      fin_pixel  = tail.best_code;
      fin_status = (tail.best_dist == '0) ? ST_EXACT : ST_NEAREST;
    end
  end

  // fill count, the only table state that reset touches
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fin_write) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_pixel  <= fin_pixel;
      out_status <= fin_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_pixel;
  assign m_tuser  = out_status;

  // never more than one request in the row
  `PALNC_ASSERT_IMP(a_one_in_flight, 1'b1, $onehot0(tok_vld))
  // fill count stays within the table
  `PALNC_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(TABLE_DEPTH))
  // a taken request keeps the slave side closed until it finishes
  `PALNC_ASSERT_NXT(a_busy_after_accept, accept, busy && !s_tready)
  // a finishing request always lands in the output register
  `PALNC_ASSERT_NXT(a_finish_lands, finish, m_tvalid && !tok_vld[TABLE_DEPTH])

endmodule
